/* rtl/sdfcc_pkg.sv */
// Shared types and helper functions for the SDF octree cell classifier.
// No dependencies; used by sdfcc_isqrt and sdf_octree_cell_classify_top.
package sdfcc_pkg;

    localparam int SqrtSteps = 32;
    localparam int QuotBits  = 9;
    localparam int NormOne   = 16384;

    typedef struct packed {
        logic signed [31:0] phi;
        logic               ap_le_lower;
        logic               d_le_lim;
        logic [7:0]         nbx;
        logic [7:0]         nby;
        logic [7:0]         nbz;
    } side_t;

    typedef struct packed {
        logic       empty;
        logic       spec;
        logic [7:0] spec_val;
        logic [7:0] nbx;
        logic [7:0] nby;
        logic [7:0] nbz;
    } post_t;

    function automatic logic [7:0] normal_to_byte(input logic signed [15:0] n);
        logic signed [17:0] m;
        logic [25:0]        t;
        logic [10:0]        q;
        m = 18'(n) + 18'(NormOne);
        t = (26'(m[16:0]) << 8) - 26'(m[16:0]);
        q = t[25:15];
        if (m[17] || (m == 18'sd0))
            return 8'd0;
        else if (q > 11'd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

endpackage

/* rtl/sdfcc_isqrt.sv */
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Carries a side payload alongside; depends on sdfcc_pkg.
module sdfcc_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [63:0]        in_val,
    input  sdfcc_pkg::side_t   in_side,
    output logic               out_vld,
    output logic [31:0]        out_root,
    output sdfcc_pkg::side_t   out_side
);
    import sdfcc_pkg::*;

    logic [63:0] v_reg    [0:SqrtSteps-1];
    logic [63:0] res_reg  [0:SqrtSteps-1];
    logic        vld_reg  [0:SqrtSteps-1];
    side_t       side_reg [0:SqrtSteps-1];

    genvar k;
    generate
        for (k = 0; k < SqrtSteps; k++)
        begin : g_step
            localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
            logic [63:0] v_prev;
            logic [63:0] res_prev;
            logic        vld_prev;
            side_t       side_prev;
            logic [63:0] trial;
            logic [63:0] v_next;
            logic [63:0] res_next;

            if (k == 0)
            begin : g_first
                assign v_prev    = in_val;
                assign res_prev  = 64'd0;
                assign vld_prev  = in_vld;
                assign side_prev = in_side;
            end
            else
            begin : g_rest
                assign v_prev    = v_reg[k-1];
                assign res_prev  = res_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            always_comb
            begin
                trial = res_prev + Bit;
                if (v_prev >= trial)
                begin
                    v_next   = v_prev - trial;
                    res_next = (res_prev >> 1) + Bit;
                end
                else
                begin
                    v_next   = v_prev;
                    res_next = res_prev >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k]    <= v_next;
                    res_reg[k]  <= res_next;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[SqrtSteps-1];
    assign out_root = res_reg[SqrtSteps-1][31:0];
    assign out_side = side_reg[SqrtSteps-1];

endmodule

/* rtl/sdf_octree_cell_classify_top.sv */
// Top level of the SDF octree cell classifier: norms, cascade, byte packing.
// Depends on sdfcc_pkg and sdfcc_isqrt.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | half_x/y/z, phi_at_center, normal_x/y/z
//  out     | out_valid / out_stall| cell_empty, distance_byte, normal_x/y/z_byte
//
// One transaction per cycle unless the output stalls. Stages: two for squares and
// sums, 32 square-root stages (one root bit each), one cascade stage, nine
// quotient stages (one bit each) and the output register.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline and raises in_stall; nothing is dropped or repeated.
module sdf_octree_cell_classify_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] half_x,
    input  logic [30:0] half_y,
    input  logic [30:0] half_z,
    input  logic signed [31:0] phi_at_center,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cell_empty,
    output logic [7:0]  distance_byte,
    output logic [7:0]  normal_x_byte,
    output logic [7:0]  normal_y_byte,
    output logic [7:0]  normal_z_byte
);
    import sdfcc_pkg::*;

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage 1
    logic               s1_vld_reg;
    logic [61:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [30:0]        lower_reg;
    logic [31:0]        ap_reg;
    logic [15:0]        nm_reg;
    logic signed [31:0] phi1_reg;
    logic [7:0]         nbx1_reg, nby1_reg, nbz1_reg;

    logic [30:0] lower_next;
    logic [31:0] ap_next;
    logic [15:0] anx, any_c, anz, nm_next;

    always_comb
    begin
        lower_next = half_x;
        if (half_y > lower_next)
            lower_next = half_y;
        if (half_z > lower_next)
            lower_next = half_z;
        ap_next = phi_at_center[31] ? (~phi_at_center + 32'd1) : phi_at_center;
        anx   = normal_x[15] ? (~normal_x + 16'd1) : normal_x;
        any_c = normal_y[15] ? (~normal_y + 16'd1) : normal_y;
        anz   = normal_z[15] ? (~normal_z + 16'd1) : normal_z;
        nm_next = anx;
        if (any_c > nm_next)
            nm_next = any_c;
        if (anz > nm_next)
            nm_next = anz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= 62'(half_x) * 62'(half_x);
            sqy_reg   <= 62'(half_y) * 62'(half_y);
            sqz_reg   <= 62'(half_z) * 62'(half_z);
            lower_reg <= lower_next;
            ap_reg    <= ap_next;
            nm_reg    <= nm_next;
            phi1_reg  <= phi_at_center;
            nbx1_reg  <= normal_to_byte(normal_x);
            nby1_reg  <= normal_to_byte(normal_y);
            nbz1_reg  <= normal_to_byte(normal_z);
        end
    end

    // stage 2
    logic        s2_vld_reg;
    logic [63:0] sum_reg;
    side_t       side2_reg;
    side_t       side2_next;
    logic [47:0] d_prod;
    logic [47:0] lim;

    always_comb
    begin
        d_prod = 48'(nm_reg) * 48'(ap_reg);
        lim    = 48'(lower_reg) << 14;
        side2_next.phi         = phi1_reg;
        side2_next.ap_le_lower = (ap_reg <= 32'(lower_reg));
        side2_next.d_le_lim    = (d_prod <= lim);
        side2_next.nbx         = nbx1_reg;
        side2_next.nby         = nby1_reg;
        side2_next.nbz         = nbz1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);
            side2_reg <= side2_next;
        end
    end

    // square root
    logic        sq_vld;
    logic [31:0] root;
    side_t       sq_side;

    sdfcc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .in_val   (sum_reg),
        .in_side  (side2_reg),
        .out_vld  (sq_vld),
        .out_root (root),
        .out_side (sq_side)
    );

    // cascade stage
    logic               s3_vld_reg;
    logic [41:0]        num_reg;
    logic [32:0]        den_reg;
    post_t              post3_reg;
    logic signed [33:0] s_sum;
    logic signed [33:0] p_minus_u;
    logic               s_le0;
    logic               hit;
    logic [41:0]        s_ext;
    post_t              post3_next;
    logic [41:0]        num_next;

    always_comb
    begin
        s_sum     = 34'(sq_side.phi) + $signed({2'b00, root});
        p_minus_u = 34'(sq_side.phi) - $signed({2'b00, root});
        s_le0     = s_sum[33] || (s_sum == 34'sd0);
        hit = !s_le0 && (sq_side.ap_le_lower || (p_minus_u[33] && sq_side.d_le_lim));
        s_ext    = 42'(s_sum[32:0]);
        num_next = (s_ext << 8) - s_ext;
        post3_next.empty    = !hit;
        post3_next.spec     = (root == 32'd0) || s_le0;
        post3_next.spec_val = ((root == 32'd0) && !sq_side.phi[31]
                               && (sq_side.phi != 32'sd0)) ? 8'd255 : 8'd0;
        post3_next.nbx      = sq_side.nbx;
        post3_next.nby      = sq_side.nby;
        post3_next.nbz      = sq_side.nbz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= num_next;
            den_reg   <= {root, 1'b0};
            post3_reg <= post3_next;
        end
    end

    // quotient stages, most significant bit first
    logic [41:0]         rem_reg  [0:QuotBits-1];
    logic [QuotBits-1:0] q_reg    [0:QuotBits-1];
    logic [32:0]         dv_reg   [0:QuotBits-1];
    post_t               post_reg [0:QuotBits-1];
    logic                dq_vld_reg [0:QuotBits-1];

    genvar j;
    generate
        for (j = 0; j < QuotBits; j++)
        begin : g_quot
            localparam int Sh = QuotBits - 1 - j;
            logic [41:0]         rem_prev;
            logic [QuotBits-1:0] q_prev;
            logic [32:0]         dv_prev;
            post_t               post_prev;
            logic                vld_prev;
            logic [41:0]         dk;
            logic [41:0]         rem_next;
            logic [QuotBits-1:0] q_next;

            if (j == 0)
            begin : g_first
                assign rem_prev  = num_reg;
                assign q_prev    = '0;
                assign dv_prev   = den_reg;
                assign post_prev = post3_reg;
                assign vld_prev  = s3_vld_reg;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[j-1];
                assign q_prev    = q_reg[j-1];
                assign dv_prev   = dv_reg[j-1];
                assign post_prev = post_reg[j-1];
                assign vld_prev  = dq_vld_reg[j-1];
            end

            always_comb
            begin
                dk       = 42'(dv_prev) << Sh;
                rem_next = rem_prev;
                q_next   = q_prev;
                if (rem_prev >= dk)
                begin
                    rem_next  = rem_prev - dk;
                    q_next[Sh] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dq_vld_reg[j] <= 1'b0;
                else if (en)
                    dq_vld_reg[j] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= rem_next;
                    q_reg[j]    <= q_next;
                    dv_reg[j]   <= dv_prev;
                    post_reg[j] <= post_prev;
                end
            end
        end
    endgenerate

    // output register
    post_t               pf;
    logic [QuotBits-1:0] qf;
    logic [7:0]          dist_next;
    logic                cell_empty_reg;
    logic [7:0]          distance_byte_reg;
    logic [7:0]          nbx_reg, nby_reg, nbz_reg;

    always_comb
    begin
        pf = post_reg[QuotBits-1];
        qf = q_reg[QuotBits-1];
        if (pf.spec)
            dist_next = pf.spec_val;
        else if (qf[QuotBits-1])
            dist_next = 8'd255;
        else
            dist_next = qf[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dq_vld_reg[QuotBits-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_empty_reg    <= pf.empty;
            distance_byte_reg <= dist_next;
            nbx_reg           <= pf.nbx;
            nby_reg           <= pf.nby;
            nbz_reg           <= pf.nbz;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_empty    = cell_empty_reg;
    assign distance_byte = distance_byte_reg;
    assign normal_x_byte = nbx_reg;
    assign normal_y_byte = nby_reg;
    assign normal_z_byte = nbz_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for sdf_octree_cell_classify_top: random and directed cells
// are checked against a built-in predictor of the norms, the empty cascade and the
// byte packing. Instantiates the top-level module only and imports no package.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic [30:0]        hz;
        logic signed [31:0] phi;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } cell_t;

    typedef struct {
        logic       empty;
        logic [7:0] dbyte;
        logic [7:0] bx;
        logic [7:0] by;
        logic [7:0] bz;
    } geom_t;

    function automatic longint unsigned diag_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cell_upper(input cell_t c);
        longint unsigned x, y, z;
        x = c.hx;
        y = c.hy;
        z = c.hz;
        return diag_root(x * x + y * y + z * z);
    endfunction

    function automatic logic [7:0] unit_to_byte(input logic signed [15:0] n);
        longint t;
        t = (longint'(n) + 16384) * 255;
        if (t <= 0)
            return 8'd0;
        t = t >>> 15;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic geom_t classify_cell(input cell_t c);
        geom_t           g;
        longint unsigned lower, upper, ap, nm, d, lim, q;
        longint          p, up, s;
        logic            hit;
        lower = c.hx;
        if (c.hy > lower) lower = c.hy;
        if (c.hz > lower) lower = c.hz;
        upper = cell_upper(c);
        up    = upper;
        p     = c.phi;
        ap    = mag(p);
        if (p <= -up)
            hit = 1'b0;
        else if (ap <= lower)
            hit = 1'b1;
        else if (p >= up)
            hit = 1'b0;
        else
        begin
            nm = mag(c.nx);
            if (mag(c.ny) > nm) nm = mag(c.ny);
            if (mag(c.nz) > nm) nm = mag(c.nz);
            d   = nm * ap;
            lim = lower << 14;
            if (p < 0 && d > lim)
                hit = 1'b0;
            else
                hit = (d <= lim);
        end
        if (upper == 0)
            g.dbyte = (p > 0) ? 8'd255 : 8'd0;
        else
        begin
            s = p + up;
            if (s <= 0)
                g.dbyte = 8'd0;
            else
            begin
                q       = (longint'(s) * 255) / (upper * 2);
                g.dbyte = (q > 255) ? 8'd255 : q[7:0];
            end
        end
        g.empty = !hit;
        g.bx    = unit_to_byte(c.nx);
        g.by    = unit_to_byte(c.ny);
        g.bz    = unit_to_byte(c.nz);
        return g;
    endfunction

    class geom_scoreboard;
        geom_t pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        task report(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_cell(input cell_t c);
            pending.push_back(classify_cell(c));
        endfunction

        task check_geom(input geom_t got);
            geom_t want;
            if (pending.size() == 0)
            begin
                report("result with no cell outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.empty !== want.empty)
                report($sformatf("cell_empty %b, want %b", got.empty, want.empty));
            if (got.dbyte !== want.dbyte)
                report($sformatf("distance_byte %0d, want %0d", got.dbyte, want.dbyte));
            if (got.bx !== want.bx)
                report($sformatf("normal_x_byte %0d, want %0d", got.bx, want.bx));
            if (got.by !== want.by)
                report($sformatf("normal_y_byte %0d, want %0d", got.by, want.by));
            if (got.bz !== want.bz)
                report($sformatf("normal_z_byte %0d, want %0d", got.bz, want.bz));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [30:0]        half_x, half_y, half_z;
    logic signed [31:0] phi_at_center;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic               out_valid;
    logic               out_stall;
    logic               cell_empty;
    logic [7:0]         distance_byte, normal_x_byte, normal_y_byte, normal_z_byte;

    geom_scoreboard sb;
    bit             gaps_on;
    bit             hold_req;
    int             quiet_cycles;

    sdf_octree_cell_classify_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .half_x        (half_x),
        .half_y        (half_y),
        .half_z        (half_z),
        .phi_at_center (phi_at_center),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_empty    (cell_empty),
        .distance_byte (distance_byte),
        .normal_x_byte (normal_x_byte),
        .normal_y_byte (normal_y_byte),
        .normal_z_byte (normal_z_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_cell(input cell_t c);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        half_x        <= c.hx;
        half_y        <= c.hy;
        half_z        <= c.hz;
        phi_at_center <= c.phi;
        normal_x      <= c.nx;
        normal_y      <= c.ny;
        normal_z      <= c.nz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_cell(c);
    endtask

    function automatic cell_t make_cell(input logic [30:0] hx, input logic [30:0] hy,
                                        input logic [30:0] hz, input longint p,
                                        input int nx, input int ny, input int nz);
        cell_t c;
        c.hx = hx;
        c.hy = hy;
        c.hz = hz;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        c.phi = p[31:0];
        c.nx  = nx[15:0];
        c.ny  = ny[15:0];
        c.nz  = nz[15:0];
        return c;
    endfunction

    function automatic logic [30:0] rand_extent();
        case ($urandom_range(9))
            0:       return 31'd0;
            1:       return 31'($urandom());
            2, 3:    return 31'($urandom_range(1 << 24));
            default: return 31'($urandom_range(1 << 18));
        endcase
    endfunction

    function automatic int rand_unit();
        if ($urandom_range(9) == 0)
            return int'($signed(16'($urandom())));
        return $urandom_range(32768) - 16384;
    endfunction

    function automatic cell_t rand_cell();
        cell_t  c;
        longint up, p;
        c  = make_cell(rand_extent(), rand_extent(), rand_extent(), 0,
                       rand_unit(), rand_unit(), rand_unit());
        up = cell_upper(c);
        case ($urandom_range(7))
            0:       p = longint'($signed($urandom()));
            1:       p = ($urandom_range(1)) ? up : -up;
            2:       p = longint'(c.hx) * ($urandom_range(1) ? 1 : -1);
            default: p = longint'($urandom_range(1 << 20)) * (2 * up + 2) / (1 << 20)
                         - up - 1;
        endcase
        c.phi = make_cell(0, 0, 0, p, 0, 0, 0).phi;
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_geom('{cell_empty, distance_byte, normal_x_byte,
                            normal_y_byte, normal_z_byte});
        if (hold_req)
        begin
            out_stall <= 1'b1;
            if (quiet_cycles == 300)
            begin
                hold_req     <= 1'b0;
                quiet_cycles <= 0;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        else
            out_stall <= gaps_on && ($urandom_range(99) < 32);
    end

    int idle_count;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > 5000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [30:0] mx;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        half_x        = '0;
        half_y        = '0;
        half_z        = '0;
        phi_at_center = '0;
        normal_x      = '0;
        normal_y      = '0;
        normal_z      = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        idle_count    = 0;
        mx            = 31'h7FFFFFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero diagonal, full extents, phi extremes, normal saturation
        send_cell(make_cell(0, 0, 0, 0, 0, 0, 0));
        send_cell(make_cell(0, 0, 0, 5, 16384, -16384, 0));
        send_cell(make_cell(0, 0, 0, -5, 32767, -32768, 16383));
        send_cell(make_cell(mx, mx, mx, 2147483647, -32768, 32767, -1));
        send_cell(make_cell(mx, mx, mx, -2147483648, 16384, 16384, 16384));
        send_cell(make_cell(mx, 0, 0, -2147483647, -16384, -16384, -16384));
        send_cell(make_cell(3 << 16, 4 << 16, 0, 5 << 16, 0, 0, 16384));
        send_cell(make_cell(3 << 16, 4 << 16, 0, -(5 << 16), 0, 0, 16384));
        send_cell(make_cell(3 << 16, 4 << 16, 0, 4 << 16, 0, 0, 16384));
        send_cell(make_cell(3 << 16, 4 << 16, 0, -(4 << 16), 0, 0, 16384));
        send_cell(make_cell(3 << 16, 4 << 16, 0, 9 << 15, 12000, 0, 0));
        send_cell(make_cell(3 << 16, 4 << 16, 0, 9 << 15, 16384, 0, 0));
        send_cell(make_cell(3 << 16, 4 << 16, 0, -(9 << 15), 16384, 0, 0));
        send_cell(make_cell(3 << 16, 4 << 16, 0, -(9 << 15), 0, 12000, -100));
        send_cell(make_cell(1, 1, 1, -2, 1, -1, 0));
        send_cell(make_cell(1, 1, 1, 1, -16385, 16385, 0));
        send_cell(make_cell(0, 0, 1 << 16, 0, 8192, -8192, 1));

        for (int i = 0; i < 1840; i++)
        begin
            if (i == 300)
                hold_req <= 1'b1;
            if (i == 700)
                drain();
            gaps_on = !(i >= 1000 && i < 1300);
            send_cell(rand_cell());
        end

        in_valid <= 1'b0;
        drain();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/sdfcc_pkg.sv
rtl/sdfcc_isqrt.sv
rtl/sdf_octree_cell_classify_top.sv
bench/tb_top.sv
